FILE: design/sobel_gradient_magnitude_angle_top_defines.svh
// Assertion macros for the Sobel gradient block
`ifndef SOBEL_GRADIENT_MAGNITUDE_ANGLE_TOP_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_ANGLE_TOP_DEFINES_SVH
`ifndef SYNTH
`define SGM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SGM_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGM_ASSERT(label, clk, rst_n, prop, msg)
`define SGM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: design/sgm_pkg.sv
package sgm_pkg;

  localparam int RegWidth  = 0;
  localparam int RegHeight = 1;

  localparam int TanFrac = 32;
  localparam int TanW    = 40;
  localparam int TblSize = 128;
  localparam int MaxDeg  = 89;
  localparam real DegScale = 15019803.0 / 262144.0;

  typedef logic [TanW-1:0] tan_tbl_t [TblSize];

  typedef struct packed {
    logic        valid;
    logic        last;
    logic        gx_zero;
    logic        neg;
    logic        sat;
    logic [15:0] s;
    logic [9:0]  a;
    logic [9:0]  b;
    logic [7:0]  r;
    logic [7:0]  d;
  } cell_data_t;

  function automatic tan_tbl_t build_tan_tbl();
    tan_tbl_t t;
    real      x;
    for (int i = 0; i < TblSize; i++) begin
      if (i > MaxDeg || i == 0) begin
        t[i] = '1;
      end else begin
        x = real'(i) / DegScale;
        t[i] = TanW'(longint'($tan(x) * 4294967296.0));
      end
    end
    return t;
  endfunction

  localparam tan_tbl_t TAN_TBL = build_tan_tbl();

endpackage

FILE: design/sgm_cell.sv
module sgm_cell #(
  parameter int BIT = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  sgm_pkg::cell_data_t din,
  output sgm_pkg::cell_data_t dout
);
  import sgm_pkg::*;

  logic [7:0]  r_try;
  logic [7:0]  d_try;
  logic [15:0] sq;
  logic [TanW-1:0] tv;
  logic [TanW+9:0] rhs;
  logic [TanW+9:0] lhs;
  logic        d_ok;
  cell_data_t  nxt;
  cell_data_t  dout_r;

  assign r_try = din.r | 8'(1 << BIT);
  assign d_try = din.d | 8'(1 << BIT);
  assign sq    = 16'(r_try) * 16'(r_try);
  assign tv    = TAN_TBL[d_try[6:0]];
  assign rhs   = (TanW+10)'(din.b) * (TanW+10)'(tv);
  assign lhs   = (TanW+10)'({din.a, {TanFrac{1'b0}}});
  // no finite ratio of the operands reaches 90 truncated degrees
  assign d_ok  = (d_try <= 8'(MaxDeg)) && (lhs >= rhs);

  always_comb begin
    nxt = din;
    if (sq <= din.s) nxt.r = r_try;
    if (d_ok) nxt.d = d_try;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else if (adv) begin
      dout_r <= nxt;
    end
  end

  assign dout = dout_r;
endmodule

FILE: design/sgm_window.sv
module sgm_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_fire,
  input  logic [7:0]          pixel,
  input  logic [10:0]         image_width,
  input  logic [11:0]         image_height,
  output sgm_pkg::cell_data_t cell_in
);
  import sgm_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [7:0] mid_mem [MAX_WIDTH];
  logic [7:0] top_mem [MAX_WIDTH];

  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic [CW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic          col_end, row_end;

  logic          a_valid_r, a_emit_r, a_last_r;
  logic [AW-1:0] a_idx_r;
  logic [7:0]    a_px_r, a_top_r, a_mid_r;

  logic          b_emit_r, b_last_r;
  logic [7:0]    win_r [9];

  logic signed [10:0] gx, gy;
  logic [21:0]        s_full;

  always_comb begin
    if (image_width < 11'd3) w_eff = CW'(3);
    else if (32'(image_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    h_eff   = (image_height < 12'd3) ? 12'd3 : image_height;
    col_end = (32'(col_r) + 1) >= 32'(w_eff);
    row_end = (13'(row_r) + 13'd1) >= 13'(h_eff);
    col_nxt = col_end ? '0 : col_r + CW'(1);
    row_nxt = col_end ? (row_end ? 12'd0 : row_r + 12'd1) : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_fire;
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_fire) begin
      a_idx_r  <= col_r[AW-1:0];
      a_px_r   <= pixel;
      a_emit_r <= (row_r >= 12'd2) && (col_r >= CW'(2));
      a_last_r <= row_end && col_end;
      a_top_r  <= top_mem[col_r[AW-1:0]];
      a_mid_r  <= mid_mem[col_r[AW-1:0]];
    end
    if (adv && a_valid_r) begin
      mid_mem[a_idx_r] <= a_px_r;
      top_mem[a_idx_r] <= a_mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_emit_r <= 1'b0;
      b_last_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= 8'd0;
    end else if (adv) begin
      b_emit_r <= a_valid_r && a_emit_r;
      b_last_r <= a_last_r;
      if (a_valid_r) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3]   <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= a_top_r;
        win_r[5] <= a_mid_r;
        win_r[8] <= a_px_r;
      end
    end
  end

  always_comb begin
    gx = (11'(win_r[2]) + (11'(win_r[5]) << 1) + 11'(win_r[8]))
       - (11'(win_r[0]) + (11'(win_r[3]) << 1) + 11'(win_r[6]));
    gy = (11'(win_r[0]) + (11'(win_r[1]) << 1) + 11'(win_r[2]))
       - (11'(win_r[6]) + (11'(win_r[7]) << 1) + 11'(win_r[8]));
    cell_in.valid   = b_emit_r;
    cell_in.last    = b_last_r;
    cell_in.gx_zero = (gx == 11'sd0);
    cell_in.neg     = gx[10] ^ gy[10];
    cell_in.a       = 10'(gy[10] ? -gy : gy);
    cell_in.b       = 10'(gx[10] ? -gx : gx);
    s_full          = 22'(cell_in.a) * 22'(cell_in.a) + 22'(cell_in.b) * 22'(cell_in.b);
    cell_in.sat     = |s_full[21:16];
    cell_in.s       = s_full[15:0];
    cell_in.r       = 8'd0;
    cell_in.d       = 8'd0;
  end
endmodule

FILE: design/sobel_gradient_magnitude_angle_top.sv
// 3x3 Sobel gradient magnitude and direction on a raster-order grey stream.
// Input: in_tvalid/in_tready/in_tdata carries one 8-bit pixel per transfer.
// Output: out_tdata carries magnitude (unsigned) and angle in degrees
// (signed, -89..90, 90 when gx is zero); out_tlast marks the last result of
// a frame. Rows 0..1 and columns 0..1 of each line give no result; the result
// for pixel (r, c) describes the center (r-1, c-1).
// cfg port: cfg_wr_en/cfg_addr/cfg_wdata set image width (0) and height (1);
// write only while idle.
// Throughput: one pixel per clock while no result stalls. From input transfer
// to out_tvalid the path is the fetch stage, which takes the transfer, then the
// window stage, eight cells, each of which resolves one bit of the square root
// and one bit of the angle search, and then the output register.
// Stall: the whole pipeline holds while a result waits and out_tready is low;
// in_tready is low only then.
// Reset: counters and window clear, width 1024, height 768. Line stores are
// not cleared; they are written before being read in a frame.
`include "sobel_gradient_magnitude_angle_top_defines.svh"
module sobel_gradient_magnitude_angle_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] magnitude, [15:8] angle_deg
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [11:0] cfg_wdata
);
  import sgm_pkg::*;

  logic        adv, in_fire;
  logic [10:0] width_r;
  logic [11:0] height_r;
  cell_data_t  chain [9];
  logic        out_valid_r, out_last_r;
  logic [7:0]  mag_r, ang_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 12'd768;
    end else if (cfg_wr_en) begin
      unique case (32'(cfg_addr))
        RegWidth:  width_r  <= cfg_wdata[10:0];
        RegHeight: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sgm_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk, .rst_n, .adv, .in_fire,
    .pixel(in_tdata), .image_width(width_r), .image_height(height_r),
    .cell_in(chain[0])
  );

  for (genvar k = 0; k < 8; k++) begin : g_cell
    sgm_cell #(.BIT(7 - k)) u_cell (
      .clk, .rst_n, .adv, .din(chain[k]), .dout(chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[8].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last_r <= chain[8].last;
      mag_r      <= chain[8].sat ? 8'd255 : chain[8].r;
      if (chain[8].gx_zero) ang_r <= 8'd90;
      else if (chain[8].neg) ang_r <= -chain[8].d;
      else ang_r <= chain[8].d;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {ang_r, mag_r};
  assign out_tlast  = out_last_r;

  `SGM_ASSERT(a_angle_range, clk, rst_n, out_tvalid |-> ($signed(ang_r) <= 8'sd90 && $signed(ang_r) >= -8'sd90), "angle out of range")
  `SGM_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `SGM_ASSERT(a_stall_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "result lost under stall")
endmodule
